// File: sv/qecc_pkg.sv
// shared types, widths and helpers for the quality / eddy current correction core
// no dependencies; used by qecc_sqrt, qecc_div and the top level
`default_nettype none
package qecc_pkg;

  localparam int unsigned MAX_POINTS = 8192;
  localparam int unsigned SAMPLE_W   = 24;
  localparam int unsigned IDX_W      = 13;
  localparam int unsigned QP_W       = 14;
  localparam int unsigned MIN_W      = 23;
  localparam int unsigned THR_W      = 2 * MIN_W;
  localparam int unsigned CFG_W      = 23;
  localparam int unsigned CFG_IDX_W  = 1;
  localparam int unsigned OUT_W      = 32;
  localparam int unsigned PROD_W     = 2 * SAMPLE_W;
  localparam int unsigned SUM_W      = PROD_W + 1;
  localparam int unsigned MAG_W      = PROD_W;
  localparam int unsigned REF_FRAC   = 22;
  localparam int unsigned MAG_FRAC   = 8;
  localparam int unsigned RAD_W      = 64;
  localparam int unsigned ROOT_W     = RAD_W / 2;
  localparam int unsigned REM_W      = ROOT_W + 2;
  localparam int unsigned QUO_W      = 33;
  localparam int unsigned NUM_W      = 2 * QUO_W;
  localparam int unsigned LANES      = 4;
  localparam int unsigned N_PROD     = 10;
  localparam int unsigned SAT_W      = QUO_W + 1;

  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_QUALITY_POINTS = 1'b0,
    CFG_MIN_REF_MAG    = 1'b1
  } cfg_reg_t;

  typedef struct packed {
    logic [IDX_W-1:0]           point_index;
    logic signed [SAMPLE_W-1:0] sup_real;
    logic signed [SAMPLE_W-1:0] sup_imag;
    logic signed [SAMPLE_W-1:0] unsup_real;
    logic signed [SAMPLE_W-1:0] unsup_imag;
    logic signed [SAMPLE_W-1:0] ref_real;
    logic signed [SAMPLE_W-1:0] ref_imag;
  } in_item_t;

  typedef struct packed {
    logic signed [OUT_W-1:0] out_sup_real;
    logic signed [OUT_W-1:0] out_sup_imag;
    logic signed [OUT_W-1:0] out_unsup_real;
    logic signed [OUT_W-1:0] out_unsup_imag;
  } out_item_t;

  // sideband riding alongside the square root
  typedef struct packed {
    logic                           qual;
    logic                           zero_ref;
    logic                           zero_unsup;
    logic signed [SAMPLE_W-1:0]     sr;
    logic signed [SAMPLE_W-1:0]     si;
    logic [LANES-1:0]               neg;
    logic [LANES-1:0][MAG_W-1:0]    mag;
    logic [MAG_W-1:0]               msq;
  } head_t;

  // sideband riding alongside the dividers
  typedef struct packed {
    logic                       qual;
    logic                       zero_ref;
    logic                       zero_unsup;
    logic signed [SAMPLE_W-1:0] sr;
    logic signed [SAMPLE_W-1:0] si;
    logic [LANES-1:0]           neg;
    logic [LANES-1:0]           ovf;
    logic [ROOT_W-1:0]          mf;
  } tail_t;

  // sign and magnitude to saturated 32-bit two's complement
  function automatic logic [OUT_W-1:0] sat32(input logic neg, input logic [SAT_W-1:0] mag);
    logic [SAT_W-1:0] lim_n;
    logic [SAT_W-1:0] lim_p;
    logic [SAT_W-1:0] negm;
    logic [OUT_W-1:0] r;
    lim_n = SAT_W'(34'h080000000);
    lim_p = SAT_W'(34'h07FFFFFFF);
    negm  = SAT_W'(0) - mag;
    if (neg) begin
      if (mag > lim_n) r = 32'h80000000;
      else r = negm[OUT_W-1:0];
    end else begin
      if (mag > lim_p) r = 32'h7FFFFFFF;
      else r = mag[OUT_W-1:0];
    end
    return r;
  endfunction

endpackage
`default_nettype wire

// File: sv/quality_ecc_phase_correction_core.sv
// top level of the quality deconvolution / eddy current correction core
// depends on qecc_pkg, qecc_sqrt and qecc_div
//
// usage
//   an item (one complex point of suppressed, unsuppressed and reference signal) is taken
//   at a rising edge with start high; busy is always low, so an item may enter every cycle
//   each item gives exactly one result, shown for one cycle with out_valid high; the
//   receiver cannot hold results off and none is needed, as nothing inside ever waits
//   from the accepting edge to the edge that takes the result an item passes the products
//   stage, the sums stage, the square root (one root bit per stage), the divider set-up,
//   the division (one quotient bit per stage) and the output register; throughput is one
//   item per cycle
//   points below quality_points are divided by the reference (zero when the reference
//   is below min_reference_magnitude); later points get the suppressed phase minus the
//   unsuppressed phase, with the unsuppressed magnitude as the real output
//   configuration writes act at once; user makes them while no item is in flight, not enforced
//   synchronous reset clears the valid bits along the pipe and the two registers
//   (quality_points to 0, min_reference_magnitude to 4); payload is not reset
`default_nettype none
module quality_ecc_phase_correction_core (
  input  wire logic                              clk,
  input  wire logic                              rst_n,
  input  wire logic                              start,
  output logic                                   busy,
  input  wire qecc_pkg::in_item_t                in_data,
  input  wire logic                              cfg_we,
  input  wire logic [qecc_pkg::CFG_IDX_W-1:0]    cfg_index,
  input  wire logic [qecc_pkg::CFG_W-1:0]        cfg_data,
  output logic                                   out_valid,
  output qecc_pkg::out_item_t                    out_result
);

  localparam int unsigned HEAD_D = qecc_pkg::ROOT_W;
  localparam int unsigned TAIL_D = qecc_pkg::QUO_W;
  localparam int unsigned LN     = qecc_pkg::LANES;

  // configuration registers
  logic [qecc_pkg::QP_W-1:0]  qp_r,  qp_nxt;
  logic [qecc_pkg::MIN_W-1:0] min_r, min_nxt;
  logic [qecc_pkg::THR_W-1:0] thr_r;

  always_comb begin
    qp_nxt  = qp_r;
    min_nxt = min_r;
    if (cfg_we) begin
      case (cfg_index)
        qecc_pkg::CFG_QUALITY_POINTS: qp_nxt  = cfg_data[qecc_pkg::QP_W-1:0];
        qecc_pkg::CFG_MIN_REF_MAG:    min_nxt = cfg_data[qecc_pkg::MIN_W-1:0];
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      qp_r  <= '0;
      min_r <= qecc_pkg::MIN_W'(4);
    end else begin
      qp_r  <= qp_nxt;
      min_r <= min_nxt;
    end
  end

  // squared threshold, settles well before any item reaches the compare
  always_ff @(posedge clk) begin
    thr_r <= min_r * min_r;
  end

  assign busy = 1'b0;

  // stage 1: region select and the ten products
  // quality multiplies by conj(ref), ecc by conj(unsup); the squares give |ref|^2 or |unsup|^2
  logic                                   v1_r;
  logic                                   qual1_r;
  logic signed [qecc_pkg::SAMPLE_W-1:0]   sr1_r, si1_r;
  logic signed [qecc_pkg::PROD_W-1:0]     prod1_r [0:qecc_pkg::N_PROD-1];
  logic signed [qecc_pkg::PROD_W-1:0]     prod_nxt [0:qecc_pkg::N_PROD-1];
  logic                                   qual_nxt;

  always_comb begin
    logic signed [qecc_pkg::SAMPLE_W-1:0] ca;
    logic signed [qecc_pkg::SAMPLE_W-1:0] cb;
    qual_nxt = {1'b0, in_data.point_index} < qp_r;
    ca = qual_nxt ? in_data.ref_real : in_data.unsup_real;
    cb = qual_nxt ? in_data.ref_imag : in_data.unsup_imag;
    prod_nxt[0] = in_data.sup_real   * ca;
    prod_nxt[1] = in_data.sup_imag   * cb;
    prod_nxt[2] = in_data.sup_imag   * ca;
    prod_nxt[3] = in_data.sup_real   * cb;
    prod_nxt[4] = in_data.unsup_real * ca;
    prod_nxt[5] = in_data.unsup_imag * cb;
    prod_nxt[6] = in_data.unsup_imag * ca;
    prod_nxt[7] = in_data.unsup_real * cb;
    prod_nxt[8] = ca * ca;
    prod_nxt[9] = cb * cb;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) v1_r <= 1'b0;
    else v1_r <= start & ~busy;
  end

  always_ff @(posedge clk) begin
    qual1_r <= qual_nxt;
    sr1_r   <= in_data.sup_real;
    si1_r   <= in_data.sup_imag;
    prod1_r <= prod_nxt;
  end

  // stage 2: cross sums and the squared magnitude
  logic                                 v2_r;
  logic                                 qual2_r, zref2_r, zun2_r;
  logic signed [qecc_pkg::SAMPLE_W-1:0] sr2_r, si2_r;
  logic signed [qecc_pkg::SUM_W-1:0]    p2_r [0:LN-1];
  logic [qecc_pkg::MAG_W-1:0]           m2_r;
  logic signed [qecc_pkg::SUM_W-1:0]    p_nxt [0:LN-1];
  logic [qecc_pkg::MAG_W-1:0]           m_nxt;

  always_comb begin
    logic signed [qecc_pkg::SUM_W-1:0] msum;
    p_nxt[0] = qecc_pkg::SUM_W'(prod1_r[0]) + qecc_pkg::SUM_W'(prod1_r[1]);
    p_nxt[1] = qecc_pkg::SUM_W'(prod1_r[2]) - qecc_pkg::SUM_W'(prod1_r[3]);
    p_nxt[2] = qecc_pkg::SUM_W'(prod1_r[4]) + qecc_pkg::SUM_W'(prod1_r[5]);
    p_nxt[3] = qecc_pkg::SUM_W'(prod1_r[6]) - qecc_pkg::SUM_W'(prod1_r[7]);
    msum     = qecc_pkg::SUM_W'(prod1_r[8]) + qecc_pkg::SUM_W'(prod1_r[9]);
    m_nxt    = msum[qecc_pkg::MAG_W-1:0];
  end

  always_ff @(posedge clk) begin
    if (!rst_n) v2_r <= 1'b0;
    else v2_r <= v1_r;
  end

  // a zero reference is always below the threshold, even with a zero threshold
  always_ff @(posedge clk) begin
    qual2_r <= qual1_r;
    sr2_r   <= sr1_r;
    si2_r   <= si1_r;
    p2_r    <= p_nxt;
    m2_r    <= m_nxt;
    zref2_r <= (m_nxt == '0) || (m_nxt < qecc_pkg::MAG_W'(thr_r));
    zun2_r  <= (m_nxt == '0);
  end

  // square root of |ref|^2 or |unsup|^2 with 8 fractional bits, sideband delayed alongside
  logic [qecc_pkg::ROOT_W-1:0] root;
  qecc_pkg::head_t             hd_nxt;
  qecc_pkg::head_t             hd_r [0:HEAD_D-1];
  logic                        hv_r [0:HEAD_D-1];

  qecc_sqrt u_sqrt (
    .clk  (clk),
    .x    ({m2_r, {(2 * qecc_pkg::MAG_FRAC){1'b0}}}),
    .root (root)
  );

  always_comb begin
    logic signed [qecc_pkg::SUM_W-1:0] ab;
    hd_nxt.qual       = qual2_r;
    hd_nxt.zero_ref   = zref2_r;
    hd_nxt.zero_unsup = zun2_r;
    hd_nxt.sr         = sr2_r;
    hd_nxt.si         = si2_r;
    hd_nxt.msq        = m2_r;
    for (int j = 0; j < LN; j++) begin
      ab = p2_r[j][qecc_pkg::SUM_W-1] ? -p2_r[j] : p2_r[j];
      hd_nxt.neg[j] = p2_r[j][qecc_pkg::SUM_W-1];
      hd_nxt.mag[j] = ab[qecc_pkg::MAG_W-1:0];
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      for (int k = 0; k < HEAD_D; k++) hv_r[k] <= 1'b0;
    end else begin
      hv_r[0] <= v2_r;
      for (int k = 1; k < HEAD_D; k++) hv_r[k] <= hv_r[k-1];
    end
  end

  always_ff @(posedge clk) begin
    hd_r[0] <= hd_nxt;
    for (int k = 1; k < HEAD_D; k++) hd_r[k] <= hd_r[k-1];
  end

  // divider set-up
  // quality: a * 2^22 / |ref|^2 with one extra bit for rounding, overflow when a >= |ref|^2 * 2^10
  // ecc: (2 * a * 2^8 + mf) / (2 * mf), rounds half away from zero on the magnitude
  logic                        sv_r;
  qecc_pkg::tail_t             td_r, td_nxt;
  logic [qecc_pkg::MAG_W-1:0]  drem_r [0:LN-1];
  logic [qecc_pkg::QUO_W-1:0]  dnum_r [0:LN-1];
  logic [qecc_pkg::MAG_W-1:0]  dden_r [0:LN-1];
  logic [qecc_pkg::MAG_W-1:0]  drem_nxt [0:LN-1];
  logic [qecc_pkg::QUO_W-1:0]  dnum_nxt [0:LN-1];
  logic [qecc_pkg::MAG_W-1:0]  dden_nxt [0:LN-1];

  always_comb begin
    qecc_pkg::head_t            h;
    logic [qecc_pkg::NUM_W-1:0] ne;
    logic [qecc_pkg::MAG_W-1:0] r0;
    logic [qecc_pkg::MAG_W-1:0] dd;
    logic [qecc_pkg::QUO_W-1:0] nl;
    h = hd_r[HEAD_D-1];
    td_nxt.qual       = h.qual;
    td_nxt.zero_ref   = h.zero_ref;
    td_nxt.zero_unsup = h.zero_unsup;
    td_nxt.sr         = h.sr;
    td_nxt.si         = h.si;
    td_nxt.neg        = h.neg;
    td_nxt.mf         = root;
    for (int j = 0; j < LN; j++) begin
      ne = (qecc_pkg::NUM_W'(h.mag[j]) << (qecc_pkg::MAG_FRAC + 1)) + qecc_pkg::NUM_W'(root);
      if (h.qual) begin
        r0 = h.mag[j] >> (qecc_pkg::QUO_W - qecc_pkg::REF_FRAC - 1);
        nl = {h.mag[j][qecc_pkg::QUO_W-qecc_pkg::REF_FRAC-2:0],
              {(qecc_pkg::REF_FRAC + 1){1'b0}}};
        dd = h.msq;
      end else begin
        r0 = qecc_pkg::MAG_W'(ne[qecc_pkg::NUM_W-1:qecc_pkg::QUO_W]);
        nl = ne[qecc_pkg::QUO_W-1:0];
        dd = qecc_pkg::MAG_W'({root, 1'b0});
      end
      td_nxt.ovf[j] = (r0 >= dd);
      drem_nxt[j]   = (r0 >= dd) ? '0 : r0;
      dnum_nxt[j]   = nl;
      dden_nxt[j]   = dd;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) sv_r <= 1'b0;
    else sv_r <= hv_r[HEAD_D-1];
  end

  always_ff @(posedge clk) begin
    td_r   <= td_nxt;
    drem_r <= drem_nxt;
    dnum_r <= dnum_nxt;
    dden_r <= dden_nxt;
  end

  // four divider lanes and the matching sideband delay
  logic [qecc_pkg::QUO_W-1:0] quo [0:LN-1];
  qecc_pkg::tail_t            tl_r [0:TAIL_D-1];
  logic                       tv_r [0:TAIL_D-1];

  for (genvar j = 0; j < LN; j++) begin : g_lane
    qecc_div u_div (
      .clk    (clk),
      .rem0   (drem_r[j]),
      .num_lo (dnum_r[j]),
      .den    (dden_r[j]),
      .quo    (quo[j])
    );
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      for (int k = 0; k < TAIL_D; k++) tv_r[k] <= 1'b0;
    end else begin
      tv_r[0] <= sv_r;
      for (int k = 1; k < TAIL_D; k++) tv_r[k] <= tv_r[k-1];
    end
  end

  always_ff @(posedge clk) begin
    tl_r[0] <= td_r;
    for (int k = 1; k < TAIL_D; k++) tl_r[k] <= tl_r[k-1];
  end

  // output stage: rounding, saturation and region select
  logic                 out_valid_r;
  qecc_pkg::out_item_t  out_res_r, out_res_nxt;

  always_comb begin
    qecc_pkg::tail_t               t;
    logic [qecc_pkg::OUT_W-1:0]    res [0:LN-1];
    logic [qecc_pkg::SAT_W-1:0]    qr;
    logic [qecc_pkg::ROOT_W:0]     mr;
    logic [qecc_pkg::SAT_W-1:0]    big;
    t   = tl_r[TAIL_D-1];
    big = '1;
    mr  = ({1'b0, t.mf} + (qecc_pkg::ROOT_W + 1)'(1 << (qecc_pkg::MAG_FRAC - 1)))
          >> qecc_pkg::MAG_FRAC;
    for (int j = 0; j < LN; j++) begin
      qr = ({1'b0, quo[j]} + qecc_pkg::SAT_W'(1)) >> 1;
      if (t.qual) begin
        if (t.zero_ref) res[j] = '0;
        else if (t.ovf[j]) res[j] = qecc_pkg::sat32(t.neg[j], big);
        else res[j] = qecc_pkg::sat32(t.neg[j], qr);
      end else begin
        if (t.ovf[j]) res[j] = qecc_pkg::sat32(t.neg[j], big);
        else res[j] = qecc_pkg::sat32(t.neg[j], {1'b0, quo[j]});
      end
    end
    if (!t.qual) begin
      // unsuppressed zero: phase taken as zero, suppressed passes through
      if (t.zero_unsup) begin
        res[0] = qecc_pkg::OUT_W'(t.sr);
        res[1] = qecc_pkg::OUT_W'(t.si);
      end
      res[2] = qecc_pkg::sat32(1'b0, qecc_pkg::SAT_W'(mr));
      res[3] = '0;
    end
    out_res_nxt.out_sup_real   = res[0];
    out_res_nxt.out_sup_imag   = res[1];
    out_res_nxt.out_unsup_real = res[2];
    out_res_nxt.out_unsup_imag = res[3];
  end

  always_ff @(posedge clk) begin
    if (!rst_n) out_valid_r <= 1'b0;
    else out_valid_r <= tv_r[TAIL_D-1];
  end

  always_ff @(posedge clk) begin
    out_res_r <= out_res_nxt;
  end

  assign out_valid  = out_valid_r;
  assign out_result = out_res_r;

endmodule
`default_nettype wire

// File: sv/qecc_sqrt.sv
// pipelined integer square root, one root bit per register stage
// depends on qecc_pkg
`default_nettype none
module qecc_sqrt (
  input  wire logic                          clk,
  input  wire logic [qecc_pkg::RAD_W-1:0]    x,
  output logic      [qecc_pkg::ROOT_W-1:0]   root
);

  localparam int unsigned NS = qecc_pkg::ROOT_W;

  logic [qecc_pkg::REM_W-1:0]  rem_r  [0:NS-1];
  logic [qecc_pkg::ROOT_W-1:0] root_r [0:NS-1];
  logic [qecc_pkg::RAD_W-1:0]  xs_r   [0:NS-1];
  logic [qecc_pkg::REM_W-1:0]  rem_nxt  [0:NS-1];
  logic [qecc_pkg::ROOT_W-1:0] root_nxt [0:NS-1];
  logic [qecc_pkg::RAD_W-1:0]  xs_nxt   [0:NS-1];

  for (genvar k = 0; k < NS; k++) begin : g_stage
    always_comb begin
      logic [qecc_pkg::REM_W-1:0]  rp;
      logic [qecc_pkg::ROOT_W-1:0] qp;
      logic [qecc_pkg::RAD_W-1:0]  xp;
      logic [qecc_pkg::REM_W+1:0]  t;
      logic [qecc_pkg::REM_W+1:0]  trial;
      logic [qecc_pkg::REM_W+1:0]  diff;
      if (k == 0) begin
        rp = '0;
        qp = '0;
        xp = x;
      end else begin
        rp = rem_r[k-1];
        qp = root_r[k-1];
        xp = xs_r[k-1];
      end
      t     = {rp, xp[qecc_pkg::RAD_W-1 -: 2]};
      trial = {2'b00, qp, 2'b01};
      diff  = t - trial;
      if (t >= trial) begin
        rem_nxt[k]  = diff[qecc_pkg::REM_W-1:0];
        root_nxt[k] = {qp[qecc_pkg::ROOT_W-2:0], 1'b1};
      end else begin
        rem_nxt[k]  = t[qecc_pkg::REM_W-1:0];
        root_nxt[k] = {qp[qecc_pkg::ROOT_W-2:0], 1'b0};
      end
      xs_nxt[k] = {xp[qecc_pkg::RAD_W-3:0], 2'b00};
    end

    always_ff @(posedge clk) begin
      rem_r[k]  <= rem_nxt[k];
      root_r[k] <= root_nxt[k];
      xs_r[k]   <= xs_nxt[k];
    end
  end

  assign root = root_r[NS-1];

endmodule
`default_nettype wire

// File: sv/qecc_div.sv
// pipelined restoring divider, one quotient bit per register stage
// depends on qecc_pkg; caller guarantees the starting remainder is below the divisor
`default_nettype none
module qecc_div (
  input  wire logic                         clk,
  input  wire logic [qecc_pkg::MAG_W-1:0]   rem0,
  input  wire logic [qecc_pkg::QUO_W-1:0]   num_lo,
  input  wire logic [qecc_pkg::MAG_W-1:0]   den,
  output logic      [qecc_pkg::QUO_W-1:0]   quo
);

  localparam int unsigned NS = qecc_pkg::QUO_W;

  logic [qecc_pkg::MAG_W-1:0] p_r [0:NS-1];
  logic [qecc_pkg::QUO_W-1:0] n_r [0:NS-1];
  logic [qecc_pkg::MAG_W-1:0] d_r [0:NS-1];
  logic [qecc_pkg::QUO_W-1:0] q_r [0:NS-1];
  logic [qecc_pkg::MAG_W-1:0] p_nxt [0:NS-1];
  logic [qecc_pkg::QUO_W-1:0] n_nxt [0:NS-1];
  logic [qecc_pkg::MAG_W-1:0] d_nxt [0:NS-1];
  logic [qecc_pkg::QUO_W-1:0] q_nxt [0:NS-1];

  for (genvar k = 0; k < NS; k++) begin : g_stage
    always_comb begin
      logic [qecc_pkg::MAG_W-1:0] pp;
      logic [qecc_pkg::QUO_W-1:0] np;
      logic [qecc_pkg::MAG_W-1:0] dp;
      logic [qecc_pkg::QUO_W-1:0] qp;
      logic [qecc_pkg::MAG_W:0]   t;
      logic [qecc_pkg::MAG_W:0]   diff;
      if (k == 0) begin
        pp = rem0;
        np = num_lo;
        dp = den;
        qp = '0;
      end else begin
        pp = p_r[k-1];
        np = n_r[k-1];
        dp = d_r[k-1];
        qp = q_r[k-1];
      end
      t    = {pp, np[qecc_pkg::QUO_W-1]};
      diff = t - {1'b0, dp};
      if (t >= {1'b0, dp}) begin
        p_nxt[k] = diff[qecc_pkg::MAG_W-1:0];
        q_nxt[k] = {qp[qecc_pkg::QUO_W-2:0], 1'b1};
      end else begin
        p_nxt[k] = t[qecc_pkg::MAG_W-1:0];
        q_nxt[k] = {qp[qecc_pkg::QUO_W-2:0], 1'b0};
      end
      n_nxt[k] = {np[qecc_pkg::QUO_W-2:0], 1'b0};
      d_nxt[k] = dp;
    end

    always_ff @(posedge clk) begin
      p_r[k] <= p_nxt[k];
      n_r[k] <= n_nxt[k];
      d_r[k] <= d_nxt[k];
      q_r[k] <= q_nxt[k];
    end
  end

  assign quo = q_r[NS-1];

endmodule
`default_nettype wire
